// ----- hdl/elg_pkg.sv -----
// ---------------------------------------------------------------------------
// elg_pkg: shared types and constants of the exposure limit gate
// Holds the item kinds, the reason codes, the field widths and the structs
// that travel between the top level and the evaluation logic.
// ---------------------------------------------------------------------------
package elg_pkg;

  localparam int unsigned AmtW  = 40;
  localparam int unsigned CntW  = 10;
  localparam int unsigned KindW = 3;
  localparam int unsigned RsnW  = 4;
  localparam int unsigned MIdxW = 6;
  localparam int unsigned SIdxW = 8;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 232;

  localparam logic [KindW-1:0] KIND_CHK_OPEN = 3'd0;
  localparam logic [KindW-1:0] KIND_CHK_INCR = 3'd1;
  localparam logic [KindW-1:0] KIND_REC_OPEN = 3'd2;
  localparam logic [KindW-1:0] KIND_REC_INCR = 3'd3;
  localparam logic [KindW-1:0] KIND_REC_DECR = 3'd4;
  localparam logic [KindW-1:0] KIND_REC_CLOSE = 3'd5;

  localparam logic [RsnW-1:0] RSN_OK           = 4'd0;
  localparam logic [RsnW-1:0] RSN_HARD_TOTAL   = 4'd1;
  localparam logic [RsnW-1:0] RSN_HARD_MARKET  = 4'd2;
  localparam logic [RsnW-1:0] RSN_HARD_SIZE    = 4'd3;
  localparam logic [RsnW-1:0] RSN_HARD_OPEN    = 4'd4;
  localparam logic [RsnW-1:0] RSN_HARD_MCOUNT  = 4'd5;
  localparam logic [RsnW-1:0] RSN_SOFT_TOTAL   = 4'd6;
  localparam logic [RsnW-1:0] RSN_SOFT_MARKET  = 4'd7;
  localparam logic [RsnW-1:0] RSN_SOFT_SIZE    = 4'd8;
  localparam logic [RsnW-1:0] RSN_SOFT_OPEN    = 4'd9;
  localparam logic [RsnW-1:0] RSN_SOFT_MCOUNT  = 4'd10;
  localparam logic [RsnW-1:0] RSN_UNKNOWN_CLOSE = 4'd11;

  localparam logic [2:0] REG_SOFT_TOTAL   = 3'd0;
  localparam logic [2:0] REG_SOFT_MARKET  = 3'd1;
  localparam logic [2:0] REG_SOFT_SIZE    = 3'd2;
  localparam logic [2:0] REG_SOFT_OPEN    = 3'd3;
  localparam logic [2:0] REG_SOFT_PER_MKT = 3'd4;
  localparam logic [2:0] REG_HARD_TOTAL   = 3'd5;
  localparam logic [2:0] REG_HARD_MARKET  = 3'd6;
  localparam logic [2:0] REG_HARD_SIZE    = 3'd7;

  typedef struct packed {
    logic [AmtW-1:0] soft_total;
    logic [AmtW-1:0] soft_market;
    logic [AmtW-1:0] soft_size;
    logic [CntW-1:0] soft_open;
    logic [CntW-1:0] soft_per_market;
    logic [AmtW-1:0] hard_total;
    logic [AmtW-1:0] hard_market;
    logic [AmtW-1:0] hard_size;
  } cfg_t;

  // State as seen by one item, with invalid entries already read as zero.
  typedef struct packed {
    logic [AmtW-1:0] total;
    logic [CntW-1:0] open;
    logic [AmtW-1:0] mex;
    logic [CntW-1:0] mcnt;
    logic [AmtW-1:0] pex;
    logic            pvalid;
  } view_t;

  typedef struct packed {
    logic            mwe;
    logic            pwe;
    logic [AmtW-1:0] total;
    logic [CntW-1:0] open;
    logic [AmtW-1:0] mex;
    logic [CntW-1:0] mcnt;
    logic [AmtW-1:0] pex;
    logic            pvalid;
  } update_t;

  typedef struct packed {
    logic [CntW-1:0] open_count_now;
    logic [CntW-1:0] market_count_now;
    logic [AmtW-1:0] position_now;
    logic [AmtW-1:0] market_now;
    logic [AmtW-1:0] total_before;
    logic [AmtW-1:0] headroom;
    logic [AmtW-1:0] limit_hit;
    logic [RsnW-1:0] reason;
    logic            allowed;
  } result_t;

  function automatic logic [AmtW-1:0] add_sat(input logic [AmtW-1:0] a,
                                              input logic [AmtW-1:0] b);
    logic [AmtW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AmtW] ? '1 : s[AmtW-1:0];
  endfunction

  function automatic logic [AmtW-1:0] sub_floor(input logic [AmtW-1:0] a,
                                                input logic [AmtW-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  function automatic logic [AmtW-1:0] min2(input logic [AmtW-1:0] a,
                                           input logic [AmtW-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

// ----- hdl/elg_eval.sv -----
// ---------------------------------------------------------------------------
// elg_eval: limit checks and record updates for one item
// Purely combinational. Takes the registered item and the state it sees and
// returns the result fields and the new state values.
// ---------------------------------------------------------------------------
module elg_eval #(
  parameter int unsigned HARD_OPEN_LIMIT       = 64,
  parameter int unsigned HARD_PER_MARKET_LIMIT = 16
) (
  input  logic [elg_pkg::KindW-1:0] kind_i,
  input  logic [elg_pkg::AmtW-1:0]  amount_i,
  input  elg_pkg::cfg_t             cfg_i,
  input  elg_pkg::view_t            view_i,
  output elg_pkg::result_t          res_o,
  output elg_pkg::update_t          upd_o
);

  localparam int unsigned AW = elg_pkg::AmtW;
  localparam int unsigned CW = elg_pkg::CntW;
  localparam logic [CW:0] HardOpen = (CW+1)'(HARD_OPEN_LIMIT);
  localparam logic [CW:0] HardPm   = (CW+1)'(HARD_PER_MARKET_LIMIT);

  logic [AW-1:0] st, sm, ss;
  logic [CW:0]   so, spm;
  logic [AW:0]   nt, nm, np;
  logic [CW:0]   nc, nmc;
  logic [AW-1:0] cl_mex;
  logic [CW-1:0] cl_mcnt;

  always_comb begin
    st  = elg_pkg::min2(cfg_i.soft_total, cfg_i.hard_total);
    sm  = elg_pkg::min2(cfg_i.soft_market, cfg_i.hard_market);
    ss  = elg_pkg::min2(cfg_i.soft_size, cfg_i.hard_size);
    so  = ({1'b0, cfg_i.soft_open} < HardOpen) ? {1'b0, cfg_i.soft_open} : HardOpen;
    spm = ({1'b0, cfg_i.soft_per_market} < HardPm) ? {1'b0, cfg_i.soft_per_market} : HardPm;
    nt  = {1'b0, view_i.total} + {1'b0, amount_i};
    nm  = {1'b0, view_i.mex} + {1'b0, amount_i};
    np  = {1'b0, view_i.pex} + {1'b0, amount_i};
    nc  = {1'b0, view_i.open} + 1'b1;
    nmc = {1'b0, view_i.mcnt} + 1'b1;

    // Close: the market is emptied once its last position goes away.
    cl_mex  = elg_pkg::sub_floor(view_i.mex, view_i.pex);
    cl_mcnt = view_i.mcnt;
    if (view_i.mcnt != '0) begin
      cl_mcnt = view_i.mcnt - 1'b1;
      if (cl_mcnt == '0) begin
        cl_mex = '0;
      end
    end

    res_o = '0;
    res_o.total_before = view_i.total;
    upd_o.mwe    = 1'b0;
    upd_o.pwe    = 1'b0;
    upd_o.total  = view_i.total;
    upd_o.open   = view_i.open;
    upd_o.mex    = view_i.mex;
    upd_o.mcnt   = view_i.mcnt;
    upd_o.pex    = view_i.pex;
    upd_o.pvalid = view_i.pvalid;

    case (kind_i)
      elg_pkg::KIND_CHK_OPEN: begin
        if (nt > {1'b0, cfg_i.hard_total}) begin
          res_o.reason    = elg_pkg::RSN_HARD_TOTAL;
          res_o.limit_hit = cfg_i.hard_total;
          res_o.headroom  = elg_pkg::sub_floor(cfg_i.hard_total, view_i.total);
        end else if (nm > {1'b0, cfg_i.hard_market}) begin
          res_o.reason    = elg_pkg::RSN_HARD_MARKET;
          res_o.limit_hit = cfg_i.hard_market;
          res_o.headroom  = elg_pkg::sub_floor(cfg_i.hard_market, view_i.mex);
        end else if (amount_i > cfg_i.hard_size) begin
          res_o.reason    = elg_pkg::RSN_HARD_SIZE;
          res_o.limit_hit = cfg_i.hard_size;
          res_o.headroom  = cfg_i.hard_size;
        end else if (nc > HardOpen) begin
          res_o.reason    = elg_pkg::RSN_HARD_OPEN;
          res_o.limit_hit = AW'(HardOpen);
        end else if (nmc > HardPm) begin
          res_o.reason    = elg_pkg::RSN_HARD_MCOUNT;
          res_o.limit_hit = AW'(HardPm);
        end else if (nt > {1'b0, st}) begin
          res_o.reason    = elg_pkg::RSN_SOFT_TOTAL;
          res_o.limit_hit = st;
          res_o.headroom  = elg_pkg::sub_floor(st, view_i.total);
        end else if (nm > {1'b0, sm}) begin
          res_o.reason    = elg_pkg::RSN_SOFT_MARKET;
          res_o.limit_hit = sm;
          res_o.headroom  = elg_pkg::sub_floor(sm, view_i.mex);
        end else if (amount_i > ss) begin
          res_o.reason    = elg_pkg::RSN_SOFT_SIZE;
          res_o.limit_hit = ss;
          res_o.headroom  = ss;
        end else if (nc > so) begin
          res_o.reason    = elg_pkg::RSN_SOFT_OPEN;
          res_o.limit_hit = AW'(so);
        end else if (nmc > spm) begin
          res_o.reason    = elg_pkg::RSN_SOFT_MCOUNT;
          res_o.limit_hit = AW'(spm);
        end else begin
          res_o.allowed   = 1'b1;
          res_o.limit_hit = st;
          res_o.headroom  = st - nt[AW-1:0];
        end
      end
      elg_pkg::KIND_CHK_INCR: begin
        if (nt > {1'b0, cfg_i.hard_total}) begin
          res_o.reason   = elg_pkg::RSN_HARD_TOTAL;
          res_o.headroom = elg_pkg::sub_floor(cfg_i.hard_total, view_i.total);
        end else if (nm > {1'b0, cfg_i.hard_market}) begin
          res_o.reason   = elg_pkg::RSN_HARD_MARKET;
          res_o.headroom = elg_pkg::sub_floor(cfg_i.hard_market, view_i.mex);
        end else if (np > {1'b0, cfg_i.hard_size}) begin
          res_o.reason   = elg_pkg::RSN_HARD_SIZE;
          res_o.headroom = elg_pkg::sub_floor(cfg_i.hard_size, view_i.pex);
        end else if (nt > {1'b0, st}) begin
          res_o.reason   = elg_pkg::RSN_SOFT_TOTAL;
          res_o.headroom = elg_pkg::sub_floor(st, view_i.total);
        end else if (nm > {1'b0, sm}) begin
          res_o.reason   = elg_pkg::RSN_SOFT_MARKET;
          res_o.headroom = elg_pkg::sub_floor(sm, view_i.mex);
        end else if (np > {1'b0, ss}) begin
          res_o.reason   = elg_pkg::RSN_SOFT_SIZE;
          res_o.headroom = elg_pkg::sub_floor(ss, view_i.pex);
        end else begin
          res_o.allowed  = 1'b1;
          res_o.headroom = elg_pkg::min2(elg_pkg::min2(st - nt[AW-1:0], sm - nm[AW-1:0]),
                                         ss - np[AW-1:0]);
        end
        if (!res_o.allowed) begin
          res_o.total_before = '0;
        end
      end
      elg_pkg::KIND_REC_OPEN: begin
        upd_o.mwe    = 1'b1;
        upd_o.pwe    = 1'b1;
        upd_o.mex    = elg_pkg::add_sat(view_i.mex, amount_i);
        upd_o.pex    = amount_i;
        upd_o.pvalid = 1'b1;
        upd_o.mcnt   = (&view_i.mcnt) ? view_i.mcnt : view_i.mcnt + 1'b1;
        upd_o.total  = elg_pkg::add_sat(view_i.total, amount_i);
        upd_o.open   = (&view_i.open) ? view_i.open : view_i.open + 1'b1;
        res_o.allowed = 1'b1;
      end
      elg_pkg::KIND_REC_INCR: begin
        upd_o.mwe    = 1'b1;
        upd_o.pwe    = 1'b1;
        upd_o.mex    = elg_pkg::add_sat(view_i.mex, amount_i);
        upd_o.pex    = elg_pkg::add_sat(view_i.pex, amount_i);
        upd_o.pvalid = 1'b1;
        upd_o.total  = elg_pkg::add_sat(view_i.total, amount_i);
        res_o.allowed = 1'b1;
      end
      elg_pkg::KIND_REC_DECR: begin
        upd_o.mwe    = 1'b1;
        upd_o.pwe    = 1'b1;
        upd_o.mex    = elg_pkg::sub_floor(view_i.mex, amount_i);
        upd_o.pex    = elg_pkg::sub_floor(view_i.pex, amount_i);
        upd_o.pvalid = 1'b1;
        upd_o.total  = elg_pkg::sub_floor(view_i.total, amount_i);
        res_o.allowed = 1'b1;
      end
      elg_pkg::KIND_REC_CLOSE: begin
        if (!view_i.pvalid) begin
          res_o.reason = elg_pkg::RSN_UNKNOWN_CLOSE;
        end else begin
          upd_o.mwe    = 1'b1;
          upd_o.pwe    = 1'b1;
          upd_o.mex    = cl_mex;
          upd_o.mcnt   = cl_mcnt;
          upd_o.pex    = '0;
          upd_o.pvalid = 1'b0;
          upd_o.total  = elg_pkg::sub_floor(view_i.total, view_i.pex);
          upd_o.open   = (view_i.open != '0) ? view_i.open - 1'b1 : view_i.open;
          res_o.allowed = 1'b1;
        end
      end
      default: begin
      end
    endcase

    res_o.market_now       = upd_o.mex;
    res_o.market_count_now = upd_o.mcnt;
    res_o.open_count_now   = upd_o.open;
    res_o.position_now     = (kind_i == elg_pkg::KIND_CHK_OPEN || !upd_o.pvalid) ?
                             '0 : upd_o.pex;
  end

endmodule

// ----- hdl/exposure_limit_gate_top.sv -----
// ---------------------------------------------------------------------------
// exposure_limit_gate_top: pre-trade exposure gate
// Checks new or growing positions against hard and soft limits and keeps
// the running exposure per position, per market and in total.
//
//   channel  | dir | transaction
//   ---------+-----+----------------------------------------------------
//   s_axis   | in  | one request: kind, market, slot, amount
//   m_axis   | out | one result per request
//   cfg      | in  | one limit register write per cycle with cfg_we_i
//
// A request accepted into the request stage has its result registered into the
// output stage on m_axis; one request enters per cycle as long as results are
// taken. The market and position tables are read at acceptance with the write
// of the request ahead forwarded into the read data, then updated at s1_fire.
// Reset clears the counters and the per-entry valid bits; no clearing pass.
// A stalled result holds the request stage, and s_axis_tready falls with it.
// ---------------------------------------------------------------------------
module exposure_limit_gate_top #(
  parameter int unsigned MARKETS               = 64,
  parameter int unsigned POSITIONS             = 256,
  parameter int unsigned HARD_OPEN_LIMIT       = 64,
  parameter int unsigned HARD_PER_MARKET_LIMIT = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // market_index, position_slot, amount, zero pad
  input  logic [elg_pkg::InDataW-1:0]   s_axis_tdata,
  // kind
  input  logic [elg_pkg::KindW-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // allowed, reason, limit_hit, headroom, current_total, market_now,
  // position_now, market_count_now, open_count_now, zero pad
  output logic [elg_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [elg_pkg::AmtW-1:0]      cfg_data_i
);

  localparam int unsigned AW = elg_pkg::AmtW;
  localparam int unsigned CW = elg_pkg::CntW;
  localparam int unsigned MW = (MARKETS > 1) ? $clog2(MARKETS) : 1;
  localparam int unsigned PW = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam int unsigned MIdxN = 2 ** elg_pkg::MIdxW;
  localparam int unsigned SIdxN = 2 ** elg_pkg::SIdxW;
  localparam int unsigned ResW = $bits(elg_pkg::result_t);

  typedef logic [MW-1:0] mtab_t [MIdxN];
  typedef logic [PW-1:0] ptab_t [SIdxN];

  function automatic mtab_t build_mtab();
    mtab_t t;
    for (int i = 0; i < MIdxN; i++) begin
      t[i] = MW'(i % MARKETS);
    end
    return t;
  endfunction

  function automatic ptab_t build_ptab();
    ptab_t t;
    for (int i = 0; i < SIdxN; i++) begin
      t[i] = PW'(i % POSITIONS);
    end
    return t;
  endfunction

  localparam mtab_t MTab = build_mtab();
  localparam ptab_t PTab = build_ptab();

  elg_pkg::cfg_t cfg_q;

  logic                      s1_valid_q;
  logic [elg_pkg::KindW-1:0] s1_kind_q;
  logic [MW-1:0]             s1_m_q;
  logic [PW-1:0]             s1_s_q;
  logic [AW-1:0]             s1_amt_q;

  logic [AW-1:0]        total_q;
  logic [CW-1:0]        open_q;
  logic [MARKETS-1:0]   mvalid_q;
  logic [POSITIONS-1:0] pvalid_q;

  logic [AW+CW-1:0] mmem [MARKETS];
  logic [AW-1:0]    pmem [POSITIONS];
  logic [AW+CW-1:0] mrd_q;
  logic [AW-1:0]    prd_q;

  logic             out_valid_q;
  elg_pkg::result_t out_q;

  logic             in_fire, s1_fire;
  logic [MW-1:0]    in_m;
  logic [PW-1:0]    in_s;
  logic             mwe, pwe;
  logic [AW+CW-1:0] mwdata;
  elg_pkg::view_t   view;
  elg_pkg::update_t upd;
  elg_pkg::result_t res;

  assign s1_fire       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_m = MTab[s_axis_tdata[elg_pkg::MIdxW-1:0]];
  assign in_s = PTab[s_axis_tdata[elg_pkg::MIdxW +: elg_pkg::SIdxW]];

  assign mwe    = s1_fire && upd.mwe;
  assign pwe    = s1_fire && upd.pwe;
  assign mwdata = {upd.mex, upd.mcnt};

  always_comb begin
    view.total  = total_q;
    view.open   = open_q;
    view.mex    = mvalid_q[s1_m_q] ? mrd_q[CW +: AW] : '0;
    view.mcnt   = mvalid_q[s1_m_q] ? mrd_q[CW-1:0] : '0;
    view.pvalid = pvalid_q[s1_s_q];
    view.pex    = pvalid_q[s1_s_q] ? prd_q : '0;
  end

  elg_eval #(
    .HARD_OPEN_LIMIT      (HARD_OPEN_LIMIT),
    .HARD_PER_MARKET_LIMIT(HARD_PER_MARKET_LIMIT)
  ) u_eval (
    .kind_i  (s1_kind_q),
    .amount_i(s1_amt_q),
    .cfg_i   (cfg_q),
    .view_i  (view),
    .res_o   (res),
    .upd_o   (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.soft_total      <= AW'(1000000);
      cfg_q.soft_market     <= AW'(500000);
      cfg_q.soft_size       <= AW'(200000);
      cfg_q.soft_open       <= CW'(64);
      cfg_q.soft_per_market <= CW'(16);
      cfg_q.hard_total      <= AW'(1000000);
      cfg_q.hard_market     <= AW'(500000);
      cfg_q.hard_size       <= AW'(200000);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        elg_pkg::REG_SOFT_TOTAL:   cfg_q.soft_total      <= cfg_data_i;
        elg_pkg::REG_SOFT_MARKET:  cfg_q.soft_market     <= cfg_data_i;
        elg_pkg::REG_SOFT_SIZE:    cfg_q.soft_size       <= cfg_data_i;
        elg_pkg::REG_SOFT_OPEN:    cfg_q.soft_open       <= cfg_data_i[CW-1:0];
        elg_pkg::REG_SOFT_PER_MKT: cfg_q.soft_per_market <= cfg_data_i[CW-1:0];
        elg_pkg::REG_HARD_TOTAL:   cfg_q.hard_total      <= cfg_data_i;
        elg_pkg::REG_HARD_MARKET:  cfg_q.hard_market     <= cfg_data_i;
        elg_pkg::REG_HARD_SIZE:    cfg_q.hard_size       <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
      open_q      <= '0;
      mvalid_q    <= '0;
      pvalid_q    <= '0;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        total_q <= upd.total;
        open_q  <= upd.open;
      end
      if (mwe) begin
        mvalid_q[s1_m_q] <= 1'b1;
      end
      if (pwe) begin
        pvalid_q[s1_s_q] <= upd.pvalid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q <= s_axis_tuser;
      s1_m_q    <= in_m;
      s1_s_q    <= in_s;
      s1_amt_q  <= s_axis_tdata[elg_pkg::MIdxW + elg_pkg::SIdxW +: AW];
    end
    if (s1_fire) begin
      out_q <= res;
    end
  end

  // Tables read first-write-through: the request ahead may update the entry
  // at the same edge this request reads it.
  always_ff @(posedge clk_i) begin
    if (mwe) begin
      mmem[s1_m_q] <= mwdata;
    end
    if (in_fire) begin
      mrd_q <= (mwe && s1_m_q == in_m) ? mwdata : mmem[in_m];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pwe) begin
      pmem[s1_s_q] <= upd.pex;
    end
    if (in_fire) begin
      prd_q <= (pwe && s1_s_q == in_s) ? upd.pex : pmem[in_s];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(elg_pkg::OutDataW - ResW)'(0), out_q};

endmodule

// ----- hdl/elg_checker.sv -----
// ---------------------------------------------------------------------------
// elg_checker: port-level checks of the exposure limit gate
// Watches the result stream and the request handshake of the top level.
// ---------------------------------------------------------------------------
module elg_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [elg_pkg::OutDataW-1:0] m_axis_tdata
);

  logic [elg_pkg::RsnW-1:0] reason;
  logic                     allowed;
  logic [elg_pkg::AmtW-1:0] limit_hit;
  logic [elg_pkg::AmtW-1:0] headroom;

  assign allowed   = m_axis_tdata[0];
  assign reason    = m_axis_tdata[4:1];
  assign limit_hit = m_axis_tdata[44:5];
  assign headroom  = m_axis_tdata[84:45];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_ok_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && allowed |-> reason == elg_pkg::RSN_OK)
    else $error("passed item carries a rejection reason");

  a_reason_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> reason <= elg_pkg::RSN_UNKNOWN_CLOSE)
    else $error("reason code out of range");

  a_idle_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !allowed && reason == elg_pkg::RSN_OK |->
      limit_hit == '0 && headroom == '0)
    else $error("unused kind reports a limit");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(m_axis_tvalid && !m_axis_tready) && m_axis_tvalid && !m_axis_tready
      && $past(!s_axis_tready) |-> !s_axis_tready)
    else $error("request taken while result path is blocked");

endmodule

bind exposure_limit_gate_top elg_checker u_elg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
